### rtl/insulation_monitor_scan_sequencer_macros.svh
// ---------------------------------------------------------------------------
// Insulation monitor scan sequencer: assertion macros
// Shared concurrent assertion forms. Each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef INSULATION_MONITOR_SCAN_SEQUENCER_MACROS_SVH
`define INSULATION_MONITOR_SCAN_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define IMS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ims assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define IMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ims assertion failed");
`else
`define IMS_ASSERT_SAME(lbl, ante, cons)
`define IMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/ims_pkg.sv
// ---------------------------------------------------------------------------
// Insulation monitor scan sequencer package
// Shared types, codes, constants and the sensor multiplexer table.
// ---------------------------------------------------------------------------
`default_nettype none

package ims_pkg;

  // Default parameter values.
  localparam int SamplesDefault = 12;
  localparam int MaxChanDefault = 42;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BRANCH_COUNT = 2'd0;
  localparam logic [1:0] CFG_TEST_CHANNEL = 2'd1;

  // Sequencer phases of the scan.
  localparam logic [2:0] PH_OPEN   = 3'd1;
  localparam logic [2:0] PH_SELECT = 3'd2;
  localparam logic [2:0] PH_START  = 3'd3;
  localparam logic [2:0] PH_SETTLE = 3'd4;
  localparam logic [2:0] PH_SAMPLE = 3'd5;

  // Converter input selections.
  localparam logic [2:0] SEL_REF    = 3'd0;
  localparam logic [2:0] SEL_BUS    = 3'd1;
  localparam logic [2:0] SEL_BRANCH = 3'd5;

  // How a quotient turns into a result value.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_POS  = 2'd1;
  localparam logic [1:0] MODE_NEG  = 2'd2;
  localparam logic [1:0] MODE_CEIL = 2'd3;

  localparam logic signed [15:0] NoFault = 16'sd9999;

  // Divider operand widths.
  localparam int NumW = 23;
  localparam int DenW = 15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;
    logic mul;
    logic prep;
    logic div_start;
    logic fix;
    logic second;
  } ims_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish;
    logic div_done;
    logic two_beats;
  } ims_status_t;

  // Multiplexer drive byte for a branch channel.
  function automatic logic [7:0] mux_lookup(input logic [5:0] ch);
    logic [7:0] code;
    code = 8'hFF;
    case (ch)
      6'd3:  code = 8'hF0;  6'd4:  code = 8'hF4;  6'd5:  code = 8'hF2;  6'd6:  code = 8'hF6;
      6'd7:  code = 8'hF1;  6'd8:  code = 8'hF5;  6'd9:  code = 8'hF3;  6'd10: code = 8'hF7;
      6'd11: code = 8'hE8;  6'd12: code = 8'hEC;  6'd13: code = 8'hEA;  6'd14: code = 8'hEE;
      6'd15: code = 8'hE9;  6'd16: code = 8'hED;  6'd17: code = 8'hEB;  6'd18: code = 8'hEF;
      6'd19: code = 8'hD8;  6'd20: code = 8'hDC;  6'd21: code = 8'hDA;  6'd22: code = 8'hDE;
      6'd23: code = 8'hD9;  6'd24: code = 8'hDD;  6'd25: code = 8'hDB;  6'd26: code = 8'hDF;
      6'd27: code = 8'hB8;  6'd28: code = 8'hBC;  6'd29: code = 8'hBA;  6'd30: code = 8'hBE;
      6'd31: code = 8'hB9;  6'd32: code = 8'hBD;  6'd33: code = 8'hBB;  6'd34: code = 8'hBF;
      6'd35: code = 8'h78;  6'd36: code = 8'h7C;  6'd37: code = 8'h7A;  6'd38: code = 8'h7E;
      6'd39: code = 8'h79;  6'd40: code = 8'h7D;  6'd41: code = 8'h7B;  6'd42: code = 8'h7F;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### rtl/ims_div.sv
// ---------------------------------------------------------------------------
// Insulation monitor scan sequencer: divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "insulation_monitor_scan_sequencer_macros.svh"

module ims_div import ims_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [NumW-1:0]      quo,
  output logic                 rem_nz
);

  localparam logic [4:0] LastCnt = 5'(NumW - 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [DenW-1:0] rem_r, rem_nxt;
  logic [DenW:0]   trial;

  // One trial subtraction per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, quo_r[NumW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = LastCnt;
      quo_nxt  = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = DenW'(trial - {1'b0, den});
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DenW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Quotient and remainder.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign quo    = quo_r;
  assign rem_nz = (rem_r != '0);

  `IMS_ASSERT_NEXT(a_div_finishes, busy_r && !start && cnt_r == '0, done_r && !busy_r)

endmodule

`default_nettype wire

### rtl/ims_ctrl.sv
// ---------------------------------------------------------------------------
// Insulation monitor scan sequencer: controller
// Steps one tick through acceptance, measurement math when it completes a channel, and result beats.
// ---------------------------------------------------------------------------
`default_nettype none
`include "insulation_monitor_scan_sequencer_macros.svh"

module ims_ctrl import ims_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire ims_status_t status,
  output ims_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIX    = 3'd5;
  localparam logic [2:0] ST_OUT0   = 3'd6;
  localparam logic [2:0] ST_OUT1   = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.step  = 1'b1;
          state_nxt = status.finish ? ST_MUL : ST_OUT0;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_OUT0;
      end
      ST_OUT0: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = status.two_beats ? ST_OUT1 : ST_IDLE;
        end
      end
      ST_OUT1: begin
        out_tvalid = 1'b1;
        cmd.second = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `IMS_ASSERT_SAME(a_out_blocks_in, out_tvalid, !in_tready)
  `IMS_ASSERT_NEXT(a_plain_tick_beat, in_tvalid && in_tready && !status.finish, out_tvalid)
  `IMS_ASSERT_SAME(a_second_beat_pair, state_r == ST_OUT1, status.two_beats)

endmodule

`default_nettype wire

### rtl/ims_datapath.sv
// ---------------------------------------------------------------------------
// Insulation monitor scan sequencer: datapath
// Scan state, sample accumulation, voltage and resistance arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module ims_datapath import ims_pkg::*; #(
  parameter int SAMPLES_PER_CHANNEL = SamplesDefault,
  parameter int MAX_CHANNEL         = MaxChanDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_tuser,
  input  wire logic [15:0] in_tdata,
  input  wire ims_cmd_t    cmd,
  output ims_status_t      status,
  output logic [39:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  localparam logic [3:0] Spc    = 4'(SAMPLES_PER_CHANNEL);
  localparam logic [5:0] MaxCh  = 6'(MAX_CHANNEL);
  localparam logic [5:0] WrapAt = 6'(MAX_CHANNEL - 2);

  // Configuration and control state.
  logic [5:0] branch_count_r, test_r;
  logic [2:0] phase_r, phase_nxt;
  logic [1:0] wait_r, wait_nxt;
  logic [3:0] count_r, count_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [7:0] mux_r, mux_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic       start_r, start_nxt;
  logic       valid_r, valid_nxt;
  logic       two_r, two_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic [12:0] neg_r, neg_nxt;
  logic signed [15:0] bus_r, bus_nxt;

  // Payload registers.
  logic [14:0] sum_r, sum_nxt;
  logic [9:0]  max_r, max_nxt, min_r, min_nxt;
  logic [13:0] kept_r, kept_nxt;
  logic [12:0] v_r, v_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [NumW-1:0] num_r, num_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [5:0]  slot0_r, slot0_nxt;
  logic signed [15:0] val0_r, val0_nxt, val1_r, val1_nxt;

  // Combinational helpers.
  logic [9:0]  smp;
  logic [5:0]  lim, idx_sel, idx_base;
  logic [31:0] recip_prod;
  logic signed [15:0] d;
  logic [12:0] absd, m;
  logic [13:0] vsum;
  logic [9:0]  thr, half;
  logic        fault, d_pos, d_neg;
  logic signed [14:0] diff;
  logic [12:0] mul_a;
  logic [9:0]  mul_k;
  logic [NumW-1:0] prod;
  logic signed [24:0] nsig;
  logic signed [15:0] res;
  logic        div_done, rem_nz;
  logic [NumW-1:0] quo;

  assign smp = in_tdata[9:0];

  // Channel wrap limit and the channel chosen at selection time.
  assign lim     = (branch_count_r > WrapAt) ? MaxCh : 6'(branch_count_r + 6'd2);
  assign idx_sel = (idx_r > lim) ? '0 : idx_r;

  // Voltage: floor(kept * 3 / 5) as a multiply by a scaled reciprocal.
  assign recip_prod = 32'(kept_r) * 32'd157287;

  // Branch deviation, its threshold and the fault decision.
  assign d     = $signed({2'b00, kept_r}) - 16'sd5120;
  assign absd  = d[15] ? 13'(-d) : 13'(d);
  assign m     = 13'(-d);
  assign vsum  = {1'b0, pos_r} + {1'b0, neg_r};
  assign thr   = (vsum < 14'd1650) ? 10'd375 : 10'd750;
  assign half  = {1'b0, thr[9:1]};
  assign fault = ((idx_r != 6'd2) && (bus_r != NoFault)) ||
                 ((absd <= 13'd4120) && (absd >= 13'(thr)));
  assign d_pos = d > $signed({6'b0, half});
  assign d_neg = d < -$signed({6'b0, half});

  // Bus difference and the one shared scaling multiplier.
  assign diff  = $signed({2'b00, pos_r}) - $signed({2'b00, v_r});
  assign mul_a = (idx_r == 6'd1) ? ((diff > 15'sd0) ? v_r : pos_r) : (d_pos ? pos_r : neg_r);
  assign mul_k = (idx_r == 6'd1) ? 10'd470 : 10'd1000;
  assign prod  = NumW'(mul_a) * NumW'(mul_k);
  assign nsig  = $signed({12'b0, m}) - $signed({2'b00, prod});

  // Quotient to signed result.
  always_comb begin
    res = NoFault;
    unique case (mode_r)
      MODE_NONE: res = NoFault;
      MODE_POS:  res = $signed(quo[15:0]);
      MODE_NEG:  res = $signed(16'(-quo[15:0]));
      MODE_CEIL: res = $signed(16'(-(quo[15:0] + 16'(rem_nz))));
      default:   res = NoFault;
    endcase
  end

  // Next-state logic for a tick and for the finishing steps.
  always_comb begin
    phase_nxt = phase_r;  wait_nxt  = wait_r;   count_nxt = count_r;
    idx_nxt   = idx_r;    mux_nxt   = mux_r;    sel_nxt   = sel_r;
    start_nxt = start_r;  valid_nxt = valid_r;  two_nxt   = two_r;
    pos_nxt   = pos_r;    neg_nxt   = neg_r;    bus_nxt   = bus_r;
    sum_nxt   = sum_r;    max_nxt   = max_r;    min_nxt   = min_r;
    kept_nxt  = kept_r;   v_nxt     = v_r;      mode_nxt  = mode_r;
    num_nxt   = num_r;    den_nxt   = den_r;    slot0_nxt = slot0_r;
    val0_nxt  = val0_r;   val1_nxt  = val1_r;
    idx_base  = (idx_r == 6'd1) ? 6'd2 : idx_r;

    if (cmd.step) begin
      start_nxt = 1'b0;
      valid_nxt = 1'b0;
      two_nxt   = 1'b0;
      slot0_nxt = '0;
      val0_nxt  = '0;
      unique case (phase_r)
        PH_OPEN: begin
          if (test_r == '0) begin
            mux_nxt = 8'hFF;
          end
          phase_nxt = PH_SELECT;
          wait_nxt  = '0;
        end
        PH_SELECT: begin
          if (wait_r == 2'd3) begin
            if (test_r != '0 || mux_r == 8'hFF) begin
              idx_nxt = idx_sel;
              if (idx_sel >= 6'd3) begin
                mux_nxt = mux_lookup(idx_sel);
              end
              sel_nxt   = (idx_sel == 6'd0) ? SEL_REF :
                          (idx_sel == 6'd1) ? SEL_BUS : SEL_BRANCH;
              phase_nxt = PH_START;
            end else begin
              phase_nxt = PH_OPEN;
            end
            wait_nxt = '0;
          end else begin
            wait_nxt = wait_r + 2'd1;
          end
        end
        PH_START: begin
          if (wait_r >= 2'd2) begin
            start_nxt = 1'b1;
            phase_nxt = PH_SETTLE;
            wait_nxt  = '0;
          end else begin
            wait_nxt = wait_r + 2'd1;
          end
        end
        PH_SETTLE: begin
          if (wait_r >= 2'd2) begin
            phase_nxt = PH_SAMPLE;
            wait_nxt  = '0;
          end else begin
            wait_nxt = wait_r + 2'd1;
          end
        end
        PH_SAMPLE: begin
          if (in_tuser) begin
            if (count_r == '0) begin
              sum_nxt   = 15'(smp);
              max_nxt   = smp;
              min_nxt   = smp;
              count_nxt = 4'd1;
              start_nxt = 1'b1;
            end else if (count_r < Spc) begin
              if (smp > max_r) max_nxt = smp;
              if (smp < min_r) min_nxt = smp;
              sum_nxt   = 15'(sum_r + 15'(smp));
              count_nxt = count_r + 4'd1;
              start_nxt = 1'b1;
            end else begin
              kept_nxt  = 14'(sum_r - 15'(max_r) - 15'(min_r));
              phase_nxt = PH_OPEN;
              count_nxt = '0;
            end
          end
        end
        default: phase_nxt = PH_OPEN;
      endcase
    end

    if (cmd.mul) begin
      v_nxt = recip_prod[30:18];
    end

    // Divider operands and how to read the quotient.
    if (cmd.prep) begin
      mode_nxt = MODE_NONE;
      num_nxt  = '0;
      den_nxt  = DenW'(1);
      if (idx_r == 6'd0) begin
        mode_nxt = MODE_NONE;
      end else if (idx_r == 6'd1) begin
        if (diff > 15'sd100) begin
          mode_nxt = MODE_NEG;
          num_nxt  = prod;
          den_nxt  = DenW'(diff);
        end else if (diff < -15'sd100) begin
          mode_nxt = MODE_POS;
          num_nxt  = prod;
          den_nxt  = DenW'(-diff);
        end
      end else if (fault && d_pos) begin
        mode_nxt = MODE_POS;
        num_nxt  = NumW'(prod + NumW'(d));
        den_nxt  = {d[13:0], 1'b0};
      end else if (fault && d_neg) begin
        den_nxt = {1'b0, m, 1'b0};
        if (nsig[24]) begin
          mode_nxt = MODE_CEIL;
          num_nxt  = NumW'(-nsig);
        end else begin
          mode_nxt = MODE_POS;
          num_nxt  = NumW'(nsig);
        end
      end
    end

    // Store measurements, build result beats, move to the next channel.
    if (cmd.fix) begin
      valid_nxt = 1'b1;
      if (idx_r == 6'd0) begin
        pos_nxt   = v_r;
        val0_nxt  = $signed({3'b000, v_r});
        slot0_nxt = 6'd0;
      end else if (idx_r == 6'd1) begin
        neg_nxt   = v_r;
        bus_nxt   = res;
        val0_nxt  = $signed({3'b000, v_r});
        slot0_nxt = 6'd1;
        val1_nxt  = res;
        two_nxt   = 1'b1;
      end else begin
        val0_nxt  = res;
        slot0_nxt = idx_r;
        if (idx_r == 6'd2) begin
          bus_nxt = res;
        end
      end
      idx_nxt = (test_r == '0) ? 6'(idx_base + 6'd1) : test_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_count_r <= 6'd40;
      test_r         <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BRANCH_COUNT) branch_count_r <= cfg_data;
      if (cfg_index == CFG_TEST_CHANNEL) test_r <= cfg_data;
    end
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      wait_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
      mux_r   <= 8'hFF;
      sel_r   <= SEL_REF;
      start_r <= 1'b0;
      valid_r <= 1'b0;
      two_r   <= 1'b0;
      pos_r   <= '0;
      neg_r   <= '0;
      bus_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      mux_r   <= mux_nxt;
      sel_r   <= sel_nxt;
      start_r <= start_nxt;
      valid_r <= valid_nxt;
      two_r   <= two_nxt;
      pos_r   <= pos_nxt;
      neg_r   <= neg_nxt;
      bus_r   <= bus_nxt;
    end
  end

  // Arithmetic and result payload.
  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    max_r   <= max_nxt;
    min_r   <= min_nxt;
    kept_r  <= kept_nxt;
    v_r     <= v_nxt;
    mode_r  <= mode_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    slot0_r <= slot0_nxt;
    val0_r  <= val0_nxt;
    val1_r  <= val1_nxt;
  end

  ims_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num    (num_r),
    .den    (den_r),
    .done   (div_done),
    .quo    (quo),
    .rem_nz (rem_nz)
  );

  assign status.finish    = (phase_r == PH_SAMPLE) && in_tuser && (count_r >= Spc);
  assign status.div_done  = div_done;
  assign status.two_beats = two_r;

  // Result beat: the second beat carries the bus resistance.
  assign out_tdata = {6'b0,
                      cmd.second ? val1_r : val0_r,
                      cmd.second ? 6'd2 : slot0_r,
                      cmd.second ? 1'b0 : start_r,
                      sel_r,
                      mux_r};
  assign out_tuser = valid_r;
  assign out_tlast = cmd.second | ~two_r;

endmodule

`default_nettype wire

### rtl/insulation_monitor_scan_sequencer.sv
// ---------------------------------------------------------------------------
// Insulation monitor scan sequencer
// Scans bus and branch sensors tick by tick and reports measurements.
// ---------------------------------------------------------------------------
// One input beat is one timer tick. An ordinary tick's single result beat
// is offered in the cycle after the tick is accepted, and it waits there
// for out_tready. The tick that completes a channel runs the measurement
// math before its first result beat: a reciprocal multiply, operand setup
// and a restoring divide; channel 1 then gives a second beat with the bus
// insulation resistance. in_tready is high only while no tick is in
// progress. Configuration writes are always accepted and take effect at once.
`default_nettype none

module insulation_monitor_scan_sequencer import ims_pkg::*; #(
  parameter int SAMPLES_PER_CHANNEL = SamplesDefault,
  parameter int MAX_CHANNEL         = MaxChanDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  // Tick input.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [9:0] sample, [15:10] zero
  input  wire logic        in_tuser,   // [0] conversion_done
  // Result output.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] mux_code, [10:8] adc_select, [11] start_conversion,
  // [17:12] value_channel, [33:18] value, [39:34] zero
  output logic [39:0]      out_tdata,
  output logic             out_tuser,  // [0] value_valid
  output logic             out_tlast
);

  ims_cmd_t    cmd;
  ims_status_t status;

  assign cfg_ready = 1'b1;

  ims_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ims_datapath #(
    .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
    .MAX_CHANNEL         (MAX_CHANNEL)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire
